### rtl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared types and constants for the NTC thermistor table interpolator:
// item and result payloads, table entry layout, status codes, FSM states.
// ----------------------------------------------------------------------------
package ntc_pkg;

	// Defaults for the top-level parameters
	localparam int TABLE_DEPTH_DEF  = 256;
	localparam int SEARCH_STEPS_DEF = 10;

	// Fixed field widths
	localparam int RES_W  = 21;
	localparam int TEMP_W = 8;
	localparam int IDX_W  = 8;
	localparam int OUT_W  = 16;
	localparam int CFG_W  = 9;

	// Register reset value
	localparam logic [CFG_W-1:0] ENTRIES_RESET = 9'd166;

	// Result of a failed search: 127 degrees in 1/256 degree
	localparam logic signed [OUT_W-1:0] FAIL_TEMP = 16'sd32512;

	// Saturation limits
	localparam logic signed [OUT_W-1:0] TEMP_MAX = 16'sh7FFF;
	localparam logic signed [OUT_W-1:0] TEMP_MIN = 16'sh8000;

	// Divider sizing: quotient magnitude bits before saturation, counter width
	localparam int DIV_BITS = 17;
	localparam int DIV_CW   = 5;

	// Item kinds
	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_CONVERT = 1'b1;

	// Result status codes
	localparam logic [2:0] STATUS_INTERP  = 3'd0;
	localparam logic [2:0] STATUS_COLD    = 3'd1;
	localparam logic [2:0] STATUS_HOT     = 3'd2;
	localparam logic [2:0] STATUS_FAIL    = 3'd3;
	localparam logic [2:0] STATUS_WRITTEN = 3'd4;

	typedef struct packed {
		logic                     kind;
		logic [IDX_W-1:0]         entry_index;
		logic [RES_W-1:0]         entry_resistance;
		logic signed [TEMP_W-1:0] entry_temperature;
		logic [RES_W-1:0]         sample_resistance;
	} ntc_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] temperature;
		logic [2:0]              status;
	} ntc_result_t;

	typedef struct packed {
		logic [RES_W-1:0]         res;
		logic signed [TEMP_W-1:0] temp;
	} ntc_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_SEARCH,
		ST_DIFF,
		ST_MUL1,
		ST_MUL2,
		ST_DIVSET,
		ST_DIV,
		ST_FIX
	} ntc_state_t;

endpackage

### rtl/ntc_table_interpolator.sv
// ----------------------------------------------------------------------------
// ntc_table_interpolator
// Thermistor resistance to temperature by table lookup, bisection search and
// linear interpolation; the table lives in one synchronous memory.
//
//  channel   ports                      handshake
//  --------  -------------------------  ------------------------------------
//  item in   start, busy, item          taken when start && !busy
//  result    done, result               one cycle, receiver cannot stall
//  config    cfg_we, cfg_wdata          written when cfg_we, no wait
//
// A load item keeps busy low; its result follows in the next cycle. A convert
// item reads entry 0 and ends clamped cold if the sample is at or above its
// resistance, then the last entry and ends clamped hot if at or below it;
// else a bisection search of at most SEARCH_STEPS midpoint reads brackets the
// sample or fails. Then come the difference, multiply steps, divider setup
// (ends the item on equal resistances or overflow), restoring division and a
// fix-up step. Reset clears the control state and loads the entry count
// register with 166; the table is not cleared. Results are never held off.
// ----------------------------------------------------------------------------
module ntc_table_interpolator
	import ntc_pkg::*;
#(
	parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
	parameter int SEARCH_STEPS = SEARCH_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ntc_item_t         item,
	output logic              done,
	output ntc_result_t       result,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
	localparam int SW = $clog2(SEARCH_STEPS);

	ntc_state_t state_q, state_d;

	logic [CFG_W-1:0] entries_q;
	logic             done_q;
	ntc_result_t      res_q;

	// table memory
	ntc_entry_t mem [TABLE_DEPTH];
	ntc_entry_t rd_q;
	logic [IW-1:0] raddr;
	logic          mem_we;

	// search state
	logic [RES_W-1:0]         r_q;
	logic [IW-1:0]            first_q, last_q, mid_q;
	logic [SW-1:0]            step_q;
	logic [RES_W-1:0]         rf_q, rl_q;
	logic signed [TEMP_W-1:0] tf_q, tl_q;

	// interpolation operands
	logic [RES_W-1:0]         ra_q, rb_q;
	logic signed [TEMP_W-1:0] ta_q, tb_q;
	logic signed [RES_W:0]    d_q, dr_q;
	logic signed [TEMP_W:0]   dt_q;
	logic signed [29:0]       p1_q;
	logic signed [31:0]       sum_q;
	logic signed [29:0]       prod1;
	logic signed [30:0]       prod2;

	// divider
	logic [RES_W:0]          dmag_q;
	logic                    neg_q;
	logic [RES_W+1:0]        rem_q;
	logic [DIV_BITS-1:0]     low_q, quo_q;
	logic [DIV_CW-1:0]       cnt_q;
	logic [31:0]             magn_c;
	logic [RES_W:0]          dmag_c;
	logic [39:0]             dividend_c;
	logic [RES_W+1:0]        trial_c;
	logic                    qbit_c;
	logic [DIV_BITS-1:0]     quo_neg_c;

	// control
	logic accept, is_load, idx_ok, finish;
	logic ge_first, le_last, hit_hi, hit_lo, step_last, d_zero, ovf, div_last;
	logic [CW-1:0] cfg_ext;
	logic [IW-1:0] last_n, nf, nl, mid_n;
	logic [IW:0]   mid_sum;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign is_load = (item.kind == KIND_LOAD);
	assign idx_ok  = (CW'(item.entry_index) < CW'(TABLE_DEPTH));
	assign mem_we  = accept && is_load && idx_ok;

	// Clamp the entry count to [2, TABLE_DEPTH] and keep the last index
	assign cfg_ext = CW'(entries_q);
	always_comb begin
		if (cfg_ext < CW'(2)) begin
			last_n = IW'(1);
		end else if (cfg_ext > CW'(TABLE_DEPTH)) begin
			last_n = IW'(TABLE_DEPTH - 1);
		end else begin
			last_n = IW'(cfg_ext - CW'(1));
		end
	end

	// Compares on the entry just read
	assign ge_first  = (r_q >= rd_q.res);
	assign le_last   = (r_q <= rd_q.res);
	assign hit_hi    = (({1'b0, mid_q} + (IW+1)'(1)) == {1'b0, last_q}) && (r_q < rd_q.res);
	assign hit_lo    = ({1'b0, mid_q} == ({1'b0, first_q} + (IW+1)'(1))) && (r_q > rd_q.res);
	assign step_last = (step_q == SW'(SEARCH_STEPS - 1));

	// Next bracket and midpoint
	always_comb begin
		nf = first_q;
		nl = last_q;
		if (state_q == ST_SEARCH) begin
			if (r_q > rd_q.res) begin
				nl = mid_q;
			end else begin
				nf = mid_q;
			end
		end
	end
	assign mid_sum = {1'b0, nf} + {1'b0, nl};
	assign mid_n   = mid_sum[IW:1];

	// Read address: entry 0, then the last entry, then midpoints
	always_comb begin
		if (state_q == ST_IDLE) begin
			raddr = '0;
		end else if (state_q == ST_FIRST) begin
			raddr = last_q;
		end else begin
			raddr = mid_n;
		end
	end

	// Multiplier operands
	assign prod1 = ta_q * d_q;
	assign prod2 = dt_q * dr_q;

	// Divider setup and step
	assign magn_c     = sum_q[31] ? 32'(-sum_q) : 32'(sum_q);
	assign dmag_c     = d_q[RES_W] ? (RES_W+1)'(-d_q) : (RES_W+1)'(d_q);
	assign dividend_c = {magn_c, 8'h00};
	assign d_zero     = (d_q == '0);
	assign ovf        = (magn_c >= {1'b0, dmag_c, 9'b0});
	assign trial_c    = {rem_q[RES_W:0], low_q[DIV_BITS-1]};
	assign qbit_c     = (trial_c >= {1'b0, dmag_q});
	assign div_last   = (cnt_q == DIV_CW'(DIV_BITS - 1));
	assign quo_neg_c  = DIV_BITS'(0) - quo_q;

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[IW'(item.entry_index)] <= '{res: item.entry_resistance,
			                               temp: item.entry_temperature};
		end
		rd_q <= mem[raddr];
	end

	// Next state and result strobe
	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_load) begin
						finish = 1'b1;
					end else begin
						state_d = ST_FIRST;
					end
				end
			end
			ST_FIRST: begin
				if (ge_first) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				if (le_last) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit_hi || hit_lo) begin
					state_d = ST_DIFF;
				end else if (step_last) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_DIFF:  state_d = ST_MUL1;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_DIVSET;
			ST_DIVSET: begin
				if (d_zero || ovf) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				finish  = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			entries_q <= ENTRIES_RESET;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (cfg_we) begin
				entries_q <= cfg_wdata;
			end
		end
	end

	// Datapath: search, interpolate, divide
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					r_q     <= item.sample_resistance;
					first_q <= '0;
					last_q  <= last_n;
					step_q  <= '0;
					res_q   <= '{temperature: '0, status: STATUS_WRITTEN};
				end
			end
			ST_FIRST: begin
				rf_q  <= rd_q.res;
				tf_q  <= rd_q.temp;
				res_q <= '{temperature: {rd_q.temp, 8'h00}, status: STATUS_COLD};
			end
			ST_LAST: begin
				rl_q  <= rd_q.res;
				tl_q  <= rd_q.temp;
				mid_q <= mid_n;
				res_q <= '{temperature: {rd_q.temp, 8'h00}, status: STATUS_HOT};
			end
			ST_SEARCH: begin
				if (hit_hi) begin
					ra_q <= rd_q.res;
					ta_q <= rd_q.temp;
					rb_q <= rl_q;
					tb_q <= tl_q;
				end else if (hit_lo) begin
					ra_q <= rf_q;
					ta_q <= tf_q;
					rb_q <= rd_q.res;
					tb_q <= rd_q.temp;
				end else begin
					// narrow the bracket and advance
					first_q <= nf;
					last_q  <= nl;
					mid_q   <= mid_n;
					step_q  <= step_q + SW'(1);
					if (r_q > rd_q.res) begin
						rl_q <= rd_q.res;
						tl_q <= rd_q.temp;
					end else begin
						rf_q <= rd_q.res;
						tf_q <= rd_q.temp;
					end
					res_q <= '{temperature: FAIL_TEMP, status: STATUS_FAIL};
				end
			end
			ST_DIFF: begin
				d_q  <= $signed({1'b0, rb_q}) - $signed({1'b0, ra_q});
				dr_q <= $signed({1'b0, r_q}) - $signed({1'b0, ra_q});
				dt_q <= $signed({tb_q[TEMP_W-1], tb_q}) - $signed({ta_q[TEMP_W-1], ta_q});
			end
			ST_MUL1: begin
				p1_q <= prod1;
			end
			ST_MUL2: begin
				sum_q <= {{2{p1_q[29]}}, p1_q} + {prod2[30], prod2};
			end
			ST_DIVSET: begin
				dmag_q <= dmag_c;
				neg_q  <= sum_q[31] ^ d_q[RES_W];
				rem_q  <= dividend_c[39:DIV_BITS];
				low_q  <= dividend_c[DIV_BITS-1:0];
				quo_q  <= '0;
				cnt_q  <= '0;
				// equal resistances give the first temperature; overflow saturates
				if (d_zero) begin
					res_q <= '{temperature: {ta_q, 8'h00}, status: STATUS_INTERP};
				end else begin
					res_q <= '{temperature: (sum_q[31] ^ d_q[RES_W]) ? TEMP_MIN : TEMP_MAX,
					           status: STATUS_INTERP};
				end
			end
			ST_DIV: begin
				rem_q <= qbit_c ? (trial_c - {1'b0, dmag_q}) : trial_c;
				low_q <= {low_q[DIV_BITS-2:0], 1'b0};
				quo_q <= {quo_q[DIV_BITS-2:0], qbit_c};
				cnt_q <= cnt_q + DIV_CW'(1);
			end
			ST_FIX: begin
				// apply the sign and saturate to 16 bits
				if (neg_q) begin
					res_q <= '{temperature: (quo_q > DIV_BITS'(32768)) ? TEMP_MIN
					                                                  : quo_neg_c[OUT_W-1:0],
					           status: STATUS_INTERP};
				end else begin
					res_q <= '{temperature: (quo_q > DIV_BITS'(32767)) ? TEMP_MAX
					                                                  : quo_q[OUT_W-1:0],
					           status: STATUS_INTERP};
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

	// A result is only shown once the block is idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// A convert item always occupies the block
	a_convert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.kind == KIND_CONVERT) |=> busy)
		else $error("convert item did not start work");

	// A load item answers in the next cycle with the written status
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.kind == KIND_LOAD) |=>
			(done && result.status == STATUS_WRITTEN && result.temperature == '0))
		else $error("load item result missing or wrong");

	// Divider remainder stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < {1'b0, dmag_q}))
		else $error("divider remainder out of range");

endmodule
